// ===== design/b64sd_pkg.sv =====
// ----------------------------------------------------------------------------
// b64sd_pkg
// shared types and constants of the streaming base64 decoder
// ----------------------------------------------------------------------------
package b64sd_pkg;

  typedef enum logic [1:0] {
    SYM_DATA,
    SYM_PAD,
    SYM_END,
    SYM_INVALID
  } sym_kind_t;

  typedef struct packed {
    sym_kind_t  kind;
    logic [5:0] val;
  } sym_t;

  localparam logic       KIND_DATA       = 1'b0;
  localparam logic       KIND_END        = 1'b1;
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_END  = 2'd1;
  localparam logic [1:0] STATUS_BAD_CHAR = 2'd2;
  localparam logic [23:0] TOTAL_MAX      = 24'hFFFFFF;
  localparam int unsigned RUN_MAX        = 3;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        result_kind;
    logic [1:0]  end_status;
    logic [23:0] byte_total;
    logic        last_of_run;
  } res_t;

  typedef struct packed {
    logic [1:0]         count;
    res_t [RUN_MAX-1:0] slot;
  } run_t;

  function automatic sym_t classify(input logic [7:0] c);
    sym_t s;
    s.kind = SYM_INVALID;
    s.val  = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      s.kind = SYM_DATA;
      s.val  = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s.kind = SYM_DATA;
      s.val  = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s.kind = SYM_DATA;
      s.val  = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      s.kind = SYM_DATA;
      s.val  = 6'd62;
    end else if (c == 8'h2F) begin
      s.kind = SYM_DATA;
      s.val  = 6'd63;
    end else if (c == 8'h3D) begin
      s.kind = SYM_PAD;
    end else if (c == 8'h00 || c == 8'h20) begin
      s.kind = SYM_END;
    end
    return s;
  endfunction

endpackage

// ===== design/b64sd_in_if.sv =====
// ----------------------------------------------------------------------------
// b64sd_in_if
// character channel into the decoder
// ----------------------------------------------------------------------------
interface b64sd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

// ===== design/b64sd_out_if.sv =====
// ----------------------------------------------------------------------------
// b64sd_out_if
// result channel out of the decoder
// ----------------------------------------------------------------------------
interface b64sd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        result_kind;
  logic [1:0]  end_status;
  logic [23:0] byte_total;
  logic        last_of_run;

  modport source (output valid, output data_byte, output result_kind,
                  output end_status, output byte_total, output last_of_run,
                  input ready);
  modport sink   (input valid, input data_byte, input result_kind,
                  input end_status, input byte_total, input last_of_run,
                  output ready);
endinterface

// ===== design/b64sd_core.sv =====
// ----------------------------------------------------------------------------
// b64sd_core
// input register, string state and single-pass decode of one character into
// a run of up to three results
// ----------------------------------------------------------------------------
module b64sd_core #(
  parameter int COUNT_BITS = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_char,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              can_load,
  output logic              run_load,
  output b64sd_pkg::run_t   run
);

  localparam int WW = (COUNT_BITS > 24) ? COUNT_BITS : 24;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic                  strict_r;
  logic                  in_v_r;
  logic [7:0]            char_r;
  logic [1:0]            phase_r, phase_nxt;
  logic [17:0]           partial_r, partial_nxt;
  logic                  pad2_r, pad2_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [COUNT_BITS-1:0] c1, c2, c3;
  logic [23:0]           s0, s1, s2, s3;
  logic [23:0]           full;
  b64sd_pkg::sym_t       sym;
  logic                  fire;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [23:0] shown(input logic [COUNT_BITS-1:0] v);
    logic [WW-1:0] ext;
    ext = WW'(v);
    return (ext > WW'(b64sd_pkg::TOTAL_MAX)) ? b64sd_pkg::TOTAL_MAX : ext[23:0];
  endfunction

  function automatic b64sd_pkg::res_t data_res(input logic [7:0] b, input logic [23:0] t);
    b64sd_pkg::res_t r;
    r.data_byte   = b;
    r.result_kind = b64sd_pkg::KIND_DATA;
    r.end_status  = b64sd_pkg::STATUS_OK;
    r.byte_total  = t;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  function automatic b64sd_pkg::res_t end_res(input logic [1:0] st, input logic [23:0] t);
    b64sd_pkg::res_t r;
    r.data_byte   = 8'd0;
    r.result_kind = b64sd_pkg::KIND_END;
    r.end_status  = st;
    r.byte_total  = (st == b64sd_pkg::STATUS_OK) ? t : 24'd0;
    r.last_of_run = 1'b1;
    return r;
  endfunction

  assign sym  = b64sd_pkg::classify(char_r);
  assign c1   = sat_inc(count_r);
  assign c2   = sat_inc(c1);
  assign c3   = sat_inc(c2);
  assign s0   = shown(count_r);
  assign s1   = shown(c1);
  assign s2   = shown(c2);
  assign s3   = shown(c3);
  assign full = {partial_r, sym.val};

  always_comb begin
    phase_nxt   = phase_r;
    partial_nxt = partial_r;
    pad2_nxt    = pad2_r;
    count_nxt   = count_r;
    run         = '0;
    if (pad2_r) begin
      phase_nxt   = 2'd0;
      partial_nxt = '0;
      pad2_nxt    = 1'b0;
      count_nxt   = '0;
      if (sym.kind == b64sd_pkg::SYM_PAD) begin
        run.count   = 2'd2;
        run.slot[0] = data_res(partial_r[11:4], s1);
        run.slot[1] = end_res(b64sd_pkg::STATUS_OK, s1);
      end else begin
        run.count   = 2'd1;
        run.slot[0] = end_res(b64sd_pkg::STATUS_BAD_END, s0);
      end
    end else begin
      case (sym.kind)
        b64sd_pkg::SYM_END: begin
          phase_nxt   = 2'd0;
          partial_nxt = '0;
          count_nxt   = '0;
          run.count   = 2'd1;
          run.slot[0] = end_res((phase_r != 2'd0) ? b64sd_pkg::STATUS_BAD_END
                                                  : b64sd_pkg::STATUS_OK, s0);
        end
        b64sd_pkg::SYM_PAD: begin
          if (phase_r == 2'd2) begin
            pad2_nxt = 1'b1;
          end else begin
            phase_nxt   = 2'd0;
            partial_nxt = '0;
            count_nxt   = '0;
            if (phase_r == 2'd3) begin
              run.count   = 2'd3;
              run.slot[0] = data_res(partial_r[17:10], s1);
              run.slot[1] = data_res(partial_r[9:2], s2);
              run.slot[2] = end_res(b64sd_pkg::STATUS_OK, s2);
            end else begin
              run.count   = 2'd1;
              run.slot[0] = end_res(b64sd_pkg::STATUS_BAD_END, s0);
            end
          end
        end
        b64sd_pkg::SYM_INVALID: begin
          if (strict_r) begin
            phase_nxt   = 2'd0;
            partial_nxt = '0;
            count_nxt   = '0;
            run.count   = 2'd1;
            run.slot[0] = end_res(b64sd_pkg::STATUS_BAD_CHAR, s0);
          end
        end
        default: begin
          if (phase_r == 2'd3) begin
            phase_nxt   = 2'd0;
            partial_nxt = '0;
            count_nxt   = c3;
            run.count   = 2'd3;
            run.slot[0] = data_res(full[23:16], s1);
            run.slot[1] = data_res(full[15:8], s2);
            run.slot[2] = data_res(full[7:0], s3);
            run.slot[2].last_of_run = 1'b1;
          end else begin
            phase_nxt   = phase_r + 2'd1;
            partial_nxt = {partial_r[11:0], sym.val};
          end
        end
      endcase
    end
  end

  assign fire     = in_v_r && ((run.count == 2'd0) || can_load);
  assign run_load = fire && (run.count != 2'd0);
  assign in_ready = !in_v_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strict_r  <= 1'b0;
      in_v_r    <= 1'b0;
      phase_r   <= 2'd0;
      partial_r <= '0;
      pad2_r    <= 1'b0;
      count_r   <= '0;
    end else begin
      if (cfg_we) begin
        strict_r <= cfg_wdata;
      end
      if (in_valid && in_ready) begin
        in_v_r <= 1'b1;
      end else if (fire) begin
        in_v_r <= 1'b0;
      end
      if (fire) begin
        phase_r   <= phase_nxt;
        partial_r <= partial_nxt;
        pad2_r    <= pad2_nxt;
        count_r   <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      char_r <= in_char;
    end
  end

endmodule

// ===== design/b64sd_out_buf.sv =====
// ----------------------------------------------------------------------------
// b64sd_out_buf
// result register holding one run of up to three results, shifted out one
// word per cycle while the result port is ready
// ----------------------------------------------------------------------------
module b64sd_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              run_load,
  input  b64sd_pkg::run_t   run,
  output logic              can_load,
  output logic              out_valid,
  input  logic              out_ready,
  output b64sd_pkg::res_t   out_res
);

  logic [1:0]                               count_r;
  b64sd_pkg::res_t [b64sd_pkg::RUN_MAX-1:0] slot_r;

  assign out_valid = (count_r != 2'd0);
  assign out_res   = slot_r[0];
  assign can_load  = (count_r == 2'd0) || ((count_r == 2'd1) && out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else if (run_load) begin
      count_r <= run.count;
    end else if (out_valid && out_ready) begin
      count_r <= count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (run_load) begin
      slot_r <= run.slot;
    end else if (out_valid && out_ready) begin
      slot_r[0] <= slot_r[1];
      slot_r[1] <= slot_r[2];
    end
  end

endmodule

// ===== design/base64_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// base64_stream_decoder
// streaming base64 decoder, one character per word in, decoded bytes and an
// end-of-string status word out
// ----------------------------------------------------------------------------
// A character is taken every cycle while it gives no result or the result
// register can load its run. It is decoded in one pass from the input
// register into a result run of up to three words, which leaves one word per
// cycle while the result port is ready. A character that gives results holds
// the next loaded run back until the last of its words is leaving the result
// register. On typical text (three bytes per four characters) the input keeps
// up at one character per cycle while the result port is ready. A first
// result reaches the port through the input register and then the result register.
// ----------------------------------------------------------------------------
module base64_stream_decoder #(
  parameter int COUNT_BITS = 24
) (
  input  logic            clk,
  input  logic            rst_n,
  b64sd_in_if.sink        in_ch,
  b64sd_out_if.source     out_ch,
  input  logic            cfg_we,
  input  logic            cfg_wdata
);

  logic            can_load;
  logic            run_load;
  b64sd_pkg::run_t run;
  b64sd_pkg::res_t res;

  b64sd_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_char   (in_ch.char_in),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .can_load  (can_load),
    .run_load  (run_load),
    .run       (run)
  );

  b64sd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .run_load  (run_load),
    .run       (run),
    .can_load  (can_load),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (res)
  );

  assign out_ch.data_byte   = res.data_byte;
  assign out_ch.result_kind = res.result_kind;
  assign out_ch.end_status  = res.end_status;
  assign out_ch.byte_total  = res.byte_total;
  assign out_ch.last_of_run = res.last_of_run;

endmodule

// ===== design/b64sd_checker.sv =====
// ----------------------------------------------------------------------------
// b64sd_checker
// port-level checks on the decoder result channel
// ----------------------------------------------------------------------------
module b64sd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  data_byte,
  input logic        result_kind,
  input logic [1:0]  end_status,
  input logic [23:0] byte_total,
  input logic        last_of_run
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && result_kind == b64sd_pkg::KIND_END |-> last_of_run && data_byte == 8'd0)
    else $error("status word not closing its run");

  a_err_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && result_kind == b64sd_pkg::KIND_END && end_status != b64sd_pkg::STATUS_OK
    |-> byte_total == 24'd0)
    else $error("error status with non-zero total");

  a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && result_kind == b64sd_pkg::KIND_DATA
    |-> end_status == b64sd_pkg::STATUS_OK && byte_total != 24'd0)
    else $error("data word with bad status or total");

  a_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && result_kind == b64sd_pkg::KIND_END ##1
    out_valid && result_kind == b64sd_pkg::KIND_DATA |-> byte_total == 24'd1)
    else $error("count not restarted after end of string");

endmodule

bind base64_stream_decoder b64sd_checker u_b64sd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .data_byte   (out_ch.data_byte),
  .result_kind (out_ch.result_kind),
  .end_status  (out_ch.end_status),
  .byte_total  (out_ch.byte_total),
  .last_of_run (out_ch.last_of_run)
);

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the streaming base64 decoder: characters go in
// with random gaps, every decoded byte and end-of-string status word is
// checked against a predictor running alongside, and strict mode is switched
// between phases while the block is idle
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          COUNT_BITS  = 24;
  localparam int          PHASE_CHARS = 80;
  localparam int          SETTLE      = 8;
  localparam int          CYCLE_LIMIT = 300000;
  localparam int          HOLD_CYCLES = 150;
  localparam logic [7:0]  PAD_CHAR    = 8'h3D;
  localparam logic [7:0]  NUL_CHAR    = 8'h00;
  localparam logic [7:0]  SPACE_CHAR  = 8'h20;

  class b64_scoreboard;
    logic                  strict;
    logic [1:0]            quad_phase;
    logic [17:0]           sextets;
    logic                  pad_wait;
    logic [COUNT_BITS-1:0] byte_count;
    b64sd_pkg::res_t       run[$];
    b64sd_pkg::res_t       expected[$];
    int                    chars_used;
    int                    words_checked;
    int                    failures;
    int                    reported;
    int                    closed_ok;
    int                    closed_bad_end;
    int                    closed_bad_char;

    function new();
      strict         = 1'b0;
      quad_phase     = '0;
      sextets        = '0;
      pad_wait       = 1'b0;
      byte_count     = '0;
      chars_used     = 0;
      words_checked  = 0;
      failures       = 0;
      reported       = 0;
      closed_ok      = 0;
      closed_bad_end = 0;
      closed_bad_char = 0;
    endfunction

    function void sort_char(input logic [7:0] c, output b64sd_pkg::sym_kind_t k,
                            output logic [5:0] v);
      k = b64sd_pkg::SYM_DATA;
      v = '0;
      if (c >= "A" && c <= "Z") v = 6'(c - "A");
      else if (c >= "a" && c <= "z") v = 6'(c - "a" + 26);
      else if (c >= "0" && c <= "9") v = 6'(c - "0" + 52);
      else if (c == "+") v = 6'd62;
      else if (c == "/") v = 6'd63;
      else if (c == PAD_CHAR) k = b64sd_pkg::SYM_PAD;
      else if (c == NUL_CHAR || c == SPACE_CHAR) k = b64sd_pkg::SYM_END;
      else k = b64sd_pkg::SYM_INVALID;
    endfunction

    function void push_byte(input logic [7:0] b);
      b64sd_pkg::res_t r;
      if (byte_count != {COUNT_BITS{1'b1}}) byte_count++;
      r             = '0;
      r.data_byte   = b;
      r.result_kind = b64sd_pkg::KIND_DATA;
      r.end_status  = b64sd_pkg::STATUS_OK;
      r.byte_total  = (byte_count > b64sd_pkg::TOTAL_MAX) ? b64sd_pkg::TOTAL_MAX
                                                          : 24'(byte_count);
      run.push_back(r);
    endfunction

    function void push_status(input logic [1:0] status);
      b64sd_pkg::res_t r;
      r             = '0;
      r.result_kind = b64sd_pkg::KIND_END;
      r.end_status  = status;
      if (status == b64sd_pkg::STATUS_OK)
        r.byte_total = (byte_count > b64sd_pkg::TOTAL_MAX) ? b64sd_pkg::TOTAL_MAX
                                                           : 24'(byte_count);
      run.push_back(r);
      case (status)
        b64sd_pkg::STATUS_OK:      closed_ok++;
        b64sd_pkg::STATUS_BAD_END: closed_bad_end++;
        default:                   closed_bad_char++;
      endcase
      quad_phase = '0;
      sextets    = '0;
      pad_wait   = 1'b0;
      byte_count = '0;
    endfunction

    function void note_char(input logic [7:0] c);
      b64sd_pkg::sym_kind_t k;
      logic [5:0]           v;
      logic [23:0]          full;
      b64sd_pkg::res_t      r;
      sort_char(c, k, v);
      run = {};
      if (!(k == b64sd_pkg::SYM_INVALID && !strict)) chars_used++;
      if (pad_wait) begin
        if (k == b64sd_pkg::SYM_PAD) begin
          push_byte(sextets[11:4]);
          push_status(b64sd_pkg::STATUS_OK);
        end else begin
          push_status(b64sd_pkg::STATUS_BAD_END);
        end
      end else begin
        case (k)
          b64sd_pkg::SYM_END: push_status((quad_phase != 2'd0) ? b64sd_pkg::STATUS_BAD_END
                                                               : b64sd_pkg::STATUS_OK);
          b64sd_pkg::SYM_PAD: begin
            if (quad_phase < 2'd2) begin
              push_status(b64sd_pkg::STATUS_BAD_END);
            end else if (quad_phase == 2'd2) begin
              pad_wait = 1'b1;
            end else begin
              push_byte(sextets[17:10]);
              push_byte(sextets[9:2]);
              push_status(b64sd_pkg::STATUS_OK);
            end
          end
          b64sd_pkg::SYM_INVALID: if (strict) push_status(b64sd_pkg::STATUS_BAD_CHAR);
          default: begin
            if (quad_phase == 2'd3) begin
              full = {sextets, v};
              push_byte(full[23:16]);
              push_byte(full[15:8]);
              push_byte(full[7:0]);
              sextets    = '0;
              quad_phase = '0;
            end else begin
              sextets    = {sextets[11:0], v};
              quad_phase = quad_phase + 2'd1;
            end
          end
        endcase
      end
      for (int i = 0; i < run.size(); i++) begin
        r = run[i];
        r.last_of_run = (i == run.size() - 1);
        expected.push_back(r);
      end
    endfunction

    function void check_word(input b64sd_pkg::res_t got);
      b64sd_pkg::res_t want;
      words_checked++;
      if (expected.size() == 0) begin
        failures++;
        if (reported < 10)
          $display("unexpected word: byte %02h kind %0d status %0d total %0d last %0d",
                   got.data_byte, got.result_kind, got.end_status, got.byte_total,
                   got.last_of_run);
        reported++;
        return;
      end
      want = expected.pop_front();
      if (got.data_byte !== want.data_byte || got.result_kind !== want.result_kind ||
          got.end_status !== want.end_status || got.byte_total !== want.byte_total ||
          got.last_of_run !== want.last_of_run) begin
        failures++;
        if (reported < 10) begin
          $display("mismatch on word %0d: expected byte %02h kind %0d status %0d total %0d last %0d",
                   words_checked, want.data_byte, want.result_kind, want.end_status,
                   want.byte_total, want.last_of_run);
          $display("                      got byte %02h kind %0d status %0d total %0d last %0d",
                   got.data_byte, got.result_kind, got.end_status, got.byte_total,
                   got.last_of_run);
        end
        reported++;
      end
    endfunction

    function int pending();
      return expected.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  b64sd_in_if  in_ch ();
  b64sd_out_if out_ch ();

  base64_stream_decoder #(
    .COUNT_BITS (COUNT_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  b64_scoreboard sb;
  int            cycles;
  bit            sender_eager;
  bit            hold_off_req;
  int            strict_writes[2];

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, sb.pending());
      $display("base64_stream_decoder verification failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  function automatic logic [7:0] code_char(input int v);
    if (v < 26) return 8'("A" + v);
    if (v < 52) return 8'("a" + v - 26);
    if (v < 62) return 8'("0" + v - 52);
    if (v == 62) return "+";
    return "/";
  endfunction

  function automatic logic [7:0] pick_terminator();
    return ($urandom_range(0, 1) == 1) ? SPACE_CHAR : NUL_CHAR;
  endfunction

  // result side: random stalls, one long hold-off on request
  initial begin
    int              lo_left;
    int              hi_left;
    b64sd_pkg::res_t got;
    lo_left = 0;
    hi_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.data_byte   = out_ch.data_byte;
        got.result_kind = out_ch.result_kind;
        got.end_status  = out_ch.end_status;
        got.byte_total  = out_ch.byte_total;
        got.last_of_run = out_ch.last_of_run;
        sb.check_word(got);
      end
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        lo_left      = HOLD_CYCLES;
        hi_left      = 0;
      end
      if (lo_left > 0) begin
        out_ch.ready <= 1'b0;
        lo_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (hi_left > 0) begin
          hi_left--;
        end else begin
          hi_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 40 : 6);
          lo_left = pick_gap();
        end
      end
    end
  end

  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = sender_eager ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.char_in <= c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_char(c);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_strict(input logic v);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.strict = v;
    strict_writes[v]++;
  endtask

  task automatic maybe_noise();
    if ($urandom_range(0, 99) < (sb.strict ? 3 : 8))
      send_char(8'($urandom_range(0, 255)));
  endtask

  task automatic send_string();
    int quads;
    int extra;
    int ending;
    quads        = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 10) : $urandom_range(0, 3);
    ending       = $urandom_range(0, 99);
    sender_eager = ($urandom_range(0, 3) == 0);
    if (ending < 45) extra = 0;
    else if (ending < 65) extra = 2;
    else if (ending < 85) extra = 3;
    else extra = $urandom_range(0, 3);
    repeat (quads * 4 + extra) begin
      maybe_noise();
      send_char(code_char($urandom_range(0, 63)));
    end
    // well-formed endings first, then broken tails and raw noise
    if (ending < 45) begin
      send_char(pick_terminator());
    end else if (ending < 65) begin
      send_char(PAD_CHAR);
      send_char(PAD_CHAR);
    end else if (ending < 90) begin
      send_char(PAD_CHAR);
    end else if (ending < 94) begin
      send_char(pick_terminator());
    end else if (ending < 97) begin
      send_char(PAD_CHAR);
      send_char(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int failed;
    int mark;
    sb            = new();
    cycles        = 0;
    sender_eager  = 1'b0;
    hold_off_req  = 1'b0;
    strict_writes = '{0, 0};
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.char_in <= 8'h00;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: alphabet extremes, skipped byte, padding, terminator and strict bad-character cases
    write_strict(1'b0);
    send_char("+");
    send_char(8'hFF);
    send_text("/Az");
    send_char(NUL_CHAR);
    send_text("A=");
    send_text("=");
    send_text("QQ==");
    send_text("QUE=");
    send_text("QQ=x");
    write_strict(1'b1);
    send_text("QQ");
    send_char(8'h7F);
    send_text("Q ");

    // random phases, alternating strict mode
    for (int ph = 0; ph < 4; ph++) begin
      write_strict(ph % 2 == 1);
      if (ph == 2) hold_off_req = 1'b1;
      mark = sb.chars_used;
      while (sb.chars_used - mark < PHASE_CHARS) send_string();
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    failed = sb.failures + sb.pending();
    $display("run: %0d characters used, %0d words checked, strict writes %0d off / %0d on",
             sb.chars_used, sb.words_checked, strict_writes[0], strict_writes[1]);
    $display("strings closed: %0d ok, %0d bad end or padding, %0d bad character",
             sb.closed_ok, sb.closed_bad_end, sb.closed_bad_char);
    if (failed == 0) begin
      $display("base64_stream_decoder verification clean");
    end else begin
      $display("%0d failures", failed);
      $display("base64_stream_decoder verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/b64sd_pkg.sv
design/b64sd_in_if.sv
design/b64sd_out_if.sv
design/b64sd_core.sv
design/b64sd_out_buf.sv
design/base64_stream_decoder.sv
design/b64sd_checker.sv
bench/tb_top.sv
